FILE: rtl/core/assert_macros.svh
// Shared assertion macros for the angle pipeline.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check prop at every rising clk edge outside reset.
`define A2_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check that cond never holds at a rising clk edge outside reset.
`define A2_NEVER(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

FILE: rtl/core/atan2_pkg.sv
`default_nettype none
package atan2_pkg;

  localparam int INPUT_WIDTH_DEF    = 16;
  localparam int ROTATION_STEPS_DEF = 16;

  localparam int FIELD_W    = 16;
  localparam int IN_DATA_W  = 32;
  localparam int OUT_DATA_W = 16;

  // Working widths: operands are scaled to 59 bits, CORDIC gain stays below 2^61.
  localparam int SCALE_TOP  = 59;
  localparam int DW         = 62;
  localparam int ZW         = 28;
  localparam int ANGLE_FRAC = 24;
  localparam int OUT_FRAC   = 13;

  localparam int HALF_PI_Z = 26353589;
  localparam int PI_OUT    = 25736;

  localparam logic signed [OUT_DATA_W-1:0] PI_OUT_S = OUT_DATA_W'(PI_OUT);

  // atan(2^-i) * 2^24 for the first nine steps.
  localparam logic [ZW-1:0] ARC_TABLE [0:8] = '{
    ZW'(13176795), ZW'(7778716), ZW'(4110060), ZW'(2086331), ZW'(1047214),
    ZW'(524117),   ZW'(262123),  ZW'(131069),  ZW'(65536)
  };

  typedef struct packed {
    logic signed [DW-1:0] x;
    logic signed [DW-1:0] y;
    logic signed [ZW-1:0] z;
    logic                 origin;
  } atan2_item_t;

  function automatic logic signed [ZW-1:0] arc_step(input int unsigned i);
    logic signed [ZW-1:0] res;
    if (i < 9) begin
      res = ARC_TABLE[i];
    end else if (i <= ANGLE_FRAC) begin
      res = ZW'(1) << (ANGLE_FRAC - i);
    end else begin
      res = '0;
    end
    return res;
  endfunction

endpackage
`default_nettype wire

FILE: rtl/core/atan2_angle_stream.sv
// Four-quadrant arctangent, vectoring CORDIC, one micro-rotation per pipeline stage.
// Stages: input turn stage, rotation stages, rounding stage. Throughput: one (x, y) beat
// per cycle while out_tready is high; each stage holds one beat and moves up when the
// stage after it is empty or advancing, so bubbles are squeezed out.
// Reset (rst_n low, synchronous) clears the valid bit of every stage; data is not cleared.
`default_nettype none
module atan2_angle_stream #(
  parameter int INPUT_WIDTH    = atan2_pkg::INPUT_WIDTH_DEF,
  parameter int ROTATION_STEPS = atan2_pkg::ROTATION_STEPS_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  // tdata: [15:0] x_value, [31:16] y_value
  input  wire logic                              in_tvalid,
  output logic                                   in_tready,
  input  wire logic [atan2_pkg::IN_DATA_W-1:0]   in_tdata,
  // tdata: [15:0] angle
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  output logic [atan2_pkg::OUT_DATA_W-1:0]       out_tdata
);
  import atan2_pkg::*;
  `include "assert_macros.svh"

  // Beat handed from stage k to stage k+1; index 0 leaves the input turn stage.
  atan2_item_t stage_item  [0:ROTATION_STEPS];
  logic        stage_valid [0:ROTATION_STEPS];
  // Ready of whatever consumes stage_item[k].
  logic        stage_ready [0:ROTATION_STEPS];
  // Output angle lies within +/- pi.
  logic        angle_ok;

  // Scale the pair and fold the left half plane into the right one.
  atan2_prerot #(
    .INPUT_WIDTH(INPUT_WIDTH)
  ) u_prerot (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_data  (in_tdata),
    .out_valid(stage_valid[0]),
    .out_ready(stage_ready[0]),
    .out_item (stage_item[0])
  );

  // One registered micro-rotation per step; step k shifts by k.
  for (genvar k = 0; k < ROTATION_STEPS; k++) begin : g_rot
    atan2_rot_stage #(
      .STEP(k)
    ) u_rot (
      .clk      (clk),
      .rst_n    (rst_n),
      .in_valid (stage_valid[k]),
      .in_ready (stage_ready[k]),
      .in_item  (stage_item[k]),
      .out_valid(stage_valid[k+1]),
      .out_ready(stage_ready[k+1]),
      .out_item (stage_item[k+1])
    );
  end

  // Round to 13 fraction bits, clamp, zero the origin, and hold the result beat for the sink.
  atan2_round u_round (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (stage_valid[ROTATION_STEPS]),
    .in_ready (stage_ready[ROTATION_STEPS]),
    .in_item  (stage_item[ROTATION_STEPS]),
    .out_valid(out_tvalid),
    .out_ready(out_tready),
    .out_angle(out_tdata)
  );

  assign angle_ok = ($signed(out_tdata) <= PI_OUT_S) && ($signed(out_tdata) >= -PI_OUT_S);

  // An empty output stage must free the whole chain back to the input.
  `A2_ASSERT(a_ready_chain, clk, rst_n, !out_tvalid |-> in_tready, "input stalled with empty output")
  `A2_ASSERT(a_angle_range, clk, rst_n, out_tvalid |-> angle_ok, "angle beyond pi")

endmodule
`default_nettype wire

FILE: rtl/core/atan2_prerot.sv
`default_nettype none
module atan2_prerot #(
  parameter int INPUT_WIDTH = atan2_pkg::INPUT_WIDTH_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_valid,
  output logic                                  in_ready,
  input  wire logic [atan2_pkg::IN_DATA_W-1:0]  in_data,
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output atan2_pkg::atan2_item_t                out_item
);
  import atan2_pkg::*;
  `include "assert_macros.svh"

  localparam int SCALE_SH = SCALE_TOP - INPUT_WIDTH;

  logic [FIELD_W-1:0]     field_x;
  logic [FIELD_W-1:0]     field_y;
  logic [INPUT_WIDTH-1:0] raw_x;
  logic [INPUT_WIDTH-1:0] raw_y;
  logic signed [DW-1:0]   sx;
  logic signed [DW-1:0]   sy;
  atan2_item_t            item_nxt;
  atan2_item_t            item_r;
  logic                   valid_r;

  assign field_x = in_data[FIELD_W-1:0];
  assign field_y = in_data[2*FIELD_W-1:FIELD_W];

  // Take INPUT_WIDTH bits of each field; wider settings see the field zero-extended.
  if (INPUT_WIDTH <= FIELD_W) begin : g_narrow
    assign raw_x = field_x[INPUT_WIDTH-1:0];
    assign raw_y = field_y[INPUT_WIDTH-1:0];
  end else begin : g_wide
    assign raw_x = INPUT_WIDTH'(field_x);
    assign raw_y = INPUT_WIDTH'(field_y);
  end

  assign sx = DW'($signed(raw_x)) <<< SCALE_SH;
  assign sy = DW'($signed(raw_y)) <<< SCALE_SH;

  // Turn the left half plane by +/- pi/2.
  always_comb begin
    item_nxt.origin = (raw_x == '0) && (raw_y == '0);
    if (!sx[DW-1]) begin
      item_nxt.x = sx;
      item_nxt.y = sy;
      item_nxt.z = '0;
    end else if (!sy[DW-1]) begin
      item_nxt.x = sy;
      item_nxt.y = -sx;
      item_nxt.z = ZW'(HALF_PI_Z);
    end else begin
      item_nxt.x = -sy;
      item_nxt.y = sx;
      item_nxt.z = -ZW'(HALF_PI_Z);
    end
  end

  assign in_ready = !valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      item_r <= item_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_item  = item_r;

  `A2_NEVER(a_prerot_right_half, clk, rst_n, valid_r && item_r.x[DW-1], "pre-rotated x is negative")

endmodule
`default_nettype wire

FILE: rtl/core/atan2_rot_stage.sv
`default_nettype none
module atan2_rot_stage #(
  parameter int unsigned STEP = 0
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire atan2_pkg::atan2_item_t in_item,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output atan2_pkg::atan2_item_t out_item
);
  import atan2_pkg::*;

  localparam logic signed [ZW-1:0] ARC = arc_step(STEP);

  logic signed [DW-1:0] xs;
  logic signed [DW-1:0] ys;
  atan2_item_t          item_nxt;
  atan2_item_t          item_r;
  logic                 valid_r;

  assign xs = in_item.x >>> STEP;
  assign ys = in_item.y >>> STEP;

  // Rotate toward y = 0 and accumulate the angle.
  always_comb begin
    item_nxt.origin = in_item.origin;
    if (!in_item.y[DW-1]) begin
      item_nxt.x = in_item.x + ys;
      item_nxt.y = in_item.y - xs;
      item_nxt.z = in_item.z + ARC;
    end else begin
      item_nxt.x = in_item.x - ys;
      item_nxt.y = in_item.y + xs;
      item_nxt.z = in_item.z - ARC;
    end
  end

  assign in_ready = !valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      item_r <= item_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_item  = item_r;

endmodule
`default_nettype wire

FILE: rtl/core/atan2_round.sv
`default_nettype none
module atan2_round (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_valid,
  output logic                                    in_ready,
  input  wire atan2_pkg::atan2_item_t             in_item,
  output logic                                    out_valid,
  input  wire logic                               out_ready,
  output logic [atan2_pkg::OUT_DATA_W-1:0]        out_angle
);
  import atan2_pkg::*;

  localparam int RSH = ANGLE_FRAC - OUT_FRAC;

  logic signed [ZW:0]         zsum;
  logic signed [ZW:0]         zq;
  logic signed [ZW:0]         lim;
  logic [OUT_DATA_W-1:0]      angle_nxt;
  logic [OUT_DATA_W-1:0]      angle_r;
  logic                       valid_r;

  assign lim  = (ZW + 1)'(PI_OUT);
  assign zsum = (ZW + 1)'(in_item.z) + ((ZW + 1)'(1) <<< (RSH - 1));
  assign zq   = zsum >>> RSH;

  // Round half up to 13 fraction bits, clamp to +/- pi, force the origin to zero.
  always_comb begin
    if (in_item.origin) begin
      angle_nxt = '0;
    end else if (zq > lim) begin
      angle_nxt = PI_OUT_S;
    end else if (zq < -lim) begin
      angle_nxt = -PI_OUT_S;
    end else begin
      angle_nxt = zq[OUT_DATA_W-1:0];
    end
  end

  assign in_ready = !valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      angle_r <= angle_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_angle = angle_r;

endmodule
`default_nettype wire

FILE: bench/atan2_angle_checker.sv
`timescale 1ns / 1ps

module atan2_angle_checker (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  input  logic                              in_tready,
  input  logic [atan2_pkg::IN_DATA_W-1:0]   in_tdata,
  input  logic                              out_tvalid,
  input  logic                              out_tready,
  input  logic [atan2_pkg::OUT_DATA_W-1:0]  out_tdata,
  output int                                mismatch_count,
  output int                                pending_beats
);

  localparam int     FRAC_BITS  = 24;
  localparam int     ROUND_BITS = 11;
  localparam int     STEPS      = 16;
  localparam longint LIFT       = longint'(1) <<< (59 - 16);
  localparam longint QUARTER_TURN = 64'sd26353589;
  localparam longint ANGLE_LIMIT  = 64'sd25736;

  logic signed [15:0] angle_queue [$];

  // atan(2^-k) scaled by 2^24; past the table the angle equals the shift weight.
  function automatic longint arc_weight(input int k);
    longint w;
    case (k)
      0:       w = 64'sd13176795;
      1:       w = 64'sd7778716;
      2:       w = 64'sd4110060;
      3:       w = 64'sd2086331;
      4:       w = 64'sd1047214;
      5:       w = 64'sd524117;
      6:       w = 64'sd262123;
      7:       w = 64'sd131069;
      8:       w = 64'sd65536;
      default: w = (k <= FRAC_BITS) ? (longint'(1) <<< (FRAC_BITS - k)) : 0;
    endcase
    return w;
  endfunction

  function automatic logic signed [15:0] cordic_angle(input logic signed [15:0] xv,
                                                      input logic signed [15:0] yv);
    longint px, py, acc, tmp, sx, sy;
    if (xv == 16'sd0 && yv == 16'sd0) begin
      return 16'sd0;
    end
    px  = longint'(xv) * LIFT;
    py  = longint'(yv) * LIFT;
    acc = 0;
    // fold the left half plane into the right one by a quarter turn
    if (px < 0) begin
      if (py >= 0) begin
        tmp = px; px = py; py = -tmp;
        acc = QUARTER_TURN;
      end else begin
        tmp = px; px = -py; py = tmp;
        acc = -QUARTER_TURN;
      end
    end
    for (int k = 0; k < STEPS; k++) begin
      sx = px >>> k;
      sy = py >>> k;
      if (py >= 0) begin
        px  = px + sy;
        py  = py - sx;
        acc = acc + arc_weight(k);
      end else begin
        px  = px - sy;
        py  = py + sx;
        acc = acc - arc_weight(k);
      end
    end
    acc = (acc + (longint'(1) <<< (ROUND_BITS - 1))) >>> ROUND_BITS;
    if (acc > ANGLE_LIMIT)  acc = ANGLE_LIMIT;
    if (acc < -ANGLE_LIMIT) acc = -ANGLE_LIMIT;
    return acc[15:0];
  endfunction

  initial begin
    mismatch_count = 0;
    pending_beats  = 0;
  end

  always @(posedge clk) begin
    logic signed [15:0] want;
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        angle_queue.push_back(cordic_angle(in_tdata[15:0], in_tdata[31:16]));
      end
      if (out_tvalid && out_tready) begin
        if (angle_queue.size() == 0) begin
          $display("%0t: unexpected angle beat, actual %0d", $time,
                   $signed(out_tdata[15:0]));
          mismatch_count = mismatch_count + 1;
        end else begin
          want = angle_queue.pop_front();
          if (out_tdata[15:0] !== want) begin
            $display("%0t: angle mismatch, expected %0d, actual %0d", $time,
                     want, $signed(out_tdata[15:0]));
            mismatch_count = mismatch_count + 1;
          end
        end
      end
      pending_beats = angle_queue.size();
    end
  end

endmodule

FILE: bench/atan2_angle_stream_tb.sv
`timescale 1ns / 1ps

module atan2_angle_stream_tb;

  logic                              clk;
  logic                              rst_n;
  logic                              in_tvalid;
  logic                              in_tready;
  // tdata: [15:0] x_value, [31:16] y_value
  logic [atan2_pkg::IN_DATA_W-1:0]   in_tdata;
  logic                              out_tvalid;
  logic                              out_tready;
  // tdata: [15:0] angle
  logic [atan2_pkg::OUT_DATA_W-1:0]  out_tdata;

  int mismatch_count;
  int pending_beats;

  // idle odds in percent for each side, set per phase by the stimulus
  int send_idle_pct;
  int recv_idle_pct;
  // one-shot request for a long receiver hold-off
  bit hold_off_req;

  atan2_angle_stream u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  atan2_angle_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_tvalid      (in_tvalid),
    .in_tready      (in_tready),
    .in_tdata       (in_tdata),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .out_tdata      (out_tdata),
    .mismatch_count (mismatch_count),
    .pending_beats  (pending_beats)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop on a timeout far beyond the slowest legal run.
  initial begin
    #2_000_000;
    $display("FAILURE");
    $finish;
  end

  // Receiver: decide out_tready once per falling edge. On request, hold it low
  // for a long stretch so the pipeline fills and backs up onto the input.
  initial begin
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        for (int k = 0; k < 200; k++) begin
          out_tready <= 1'b0;
          @(negedge clk);
        end
      end
      out_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Drive one pair. Called at a falling edge, returns at a falling edge with
  // the beat accepted. Keep tvalid high across back-to-back beats.
  task automatic send_pair(input logic signed [15:0] xv, input logic signed [15:0] yv);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {yv, xv};
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  // Mix of random shapes: full-range noise, tiny vectors, on-axis points,
  // diagonals and corner values.
  task automatic random_pair(output logic signed [15:0] xv, output logic signed [15:0] yv);
    logic signed [15:0] corners [6];
    int pick;
    logic [15:0] mag;
    corners = '{-16'sd32768, -16'sd32767, -16'sd1, 16'sd0, 16'sd1, 16'sd32767};
    pick = $urandom_range(99);
    if (pick < 45) begin
      {yv, xv} = $urandom;
    end else if (pick < 65) begin
      xv = 16'($urandom_range(16)) - 16'sd8;
      yv = 16'($urandom_range(16)) - 16'sd8;
    end else if (pick < 80) begin
      mag = 16'($urandom);
      if ($urandom_range(1)) begin
        xv = mag;
        yv = 16'sd0;
      end else begin
        xv = 16'sd0;
        yv = mag;
      end
    end else if (pick < 92) begin
      mag = 16'($urandom_range(32767));
      xv = $urandom_range(1) ? mag : -mag;
      yv = $urandom_range(1) ? mag : -mag;
    end else begin
      xv = corners[$urandom_range(5)];
      yv = corners[$urandom_range(5)];
    end
  endtask

  task automatic random_run(input int count);
    logic signed [15:0] xv, yv;
    for (int n = 0; n < count; n++) begin
      random_pair(xv, yv);
      send_pair(xv, yv);
    end
  endtask

  initial begin
    rst_n         = 1'b0;
    in_tvalid     = 1'b0;
    in_tdata      = '0;
    hold_off_req  = 1'b0;
    send_idle_pct = 6;
    recv_idle_pct = 75;

    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: origin, the four axes, full-scale corners, the negative real
    // axis (expect +pi) and points just off it where the sum can pass pi.
    send_pair(16'sd0, 16'sd0);
    send_pair(16'sd1, 16'sd0);
    send_pair(16'sd0, 16'sd1);
    send_pair(-16'sd1, 16'sd0);
    send_pair(16'sd0, -16'sd1);
    send_pair(16'sd32767, 16'sd0);
    send_pair(-16'sd32768, 16'sd0);
    send_pair(-16'sd5, 16'sd0);
    send_pair(16'sd0, 16'sd32767);
    send_pair(16'sd0, -16'sd32768);
    send_pair(16'sd32767, 16'sd32767);
    send_pair(-16'sd32768, -16'sd32768);
    send_pair(-16'sd32768, 16'sd32767);
    send_pair(16'sd32767, -16'sd32768);
    send_pair(-16'sd1, -16'sd1);
    send_pair(-16'sd1, 16'sd1);
    send_pair(16'sd1, -16'sd1);
    send_pair(-16'sd32768, 16'sd1);
    send_pair(-16'sd32767, 16'sd1);
    send_pair(-16'sd32768, -16'sd1);
    send_pair(-16'sd1, -16'sd32768);
    send_pair(16'sd32767, 16'sd1);
    send_pair(16'sd32767, -16'sd1);
    send_pair(-16'sd100, -16'sd1);

    // Phase one: sender mostly busy, receiver mostly idle. Midway, hold the
    // receiver off while beats keep coming.
    random_run(180);
    hold_off_req = 1'b1;
    random_run(180);

    // Pause the sender until the pipeline has drained completely.
    in_tvalid <= 1'b0;
    wait (pending_beats == 0);
    @(negedge clk);

    // Phase two: swap the idle odds.
    send_idle_pct = 75;
    recv_idle_pct = 6;
    random_run(360);

    // Phase three: full rate on both sides.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    random_run(360);
    in_tvalid <= 1'b0;

    // Drain, then let the clock run on before the verdict.
    wait (pending_beats == 0);
    repeat (30) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

FILE: atan2_angle_stream.f
+incdir+rtl/core
rtl/core/atan2_pkg.sv
rtl/core/atan2_prerot.sv
rtl/core/atan2_rot_stage.sv
rtl/core/atan2_round.sv
rtl/core/atan2_angle_stream.sv
bench/atan2_angle_checker.sv
bench/atan2_angle_stream_tb.sv
